// ----- hdl/chp3d_pkg.sv -----
// -----------------------------------------------------------------------------
// chp3d_pkg
// Shared widths, register codes and types for the cubic Hermite point block.
// -----------------------------------------------------------------------------
`default_nettype none

package chp3d_pkg;

	// Coordinate and parameter formats
	localparam int COORD_W  = 16;               // signed Q8.8
	localparam int FRAC_W   = 16;               // fraction bits of t
	localparam int T_W      = FRAC_W + 1;       // t up to and including 1.0
	localparam int SQ_W     = 2 * T_W;          // t*t and t2*t products
	localparam int H_W      = FRAC_W + 4;       // signed basis values
	localparam int PROD_W   = H_W + COORD_W;    // basis times coordinate
	localparam int PT_W     = PROD_W + 1;       // sum of two products
	localparam int RND_SH   = FRAC_W - 8;       // bring basis sums to 16 fraction bits
	localparam int RND_W    = PT_W - RND_SH;    // rounded point and tangent sums
	localparam int SPROD_W  = RND_W + COORD_W;  // tangent sum times scale
	localparam int SUM_W    = SPROD_W + 1;      // final sum, 24 fraction bits
	localparam int OUT_SH   = 16;
	localparam int R_W      = SUM_W - OUT_SH;   // rounded result before saturation

	localparam int T_HALF   = 1 << (FRAC_W - 1);
	localparam int PT_HALF  = 1 << (RND_SH - 1);
	localparam int OUT_HALF = 1 << (OUT_SH - 1);

	localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_W{1'b0}}};

	// Configuration port
	localparam int CFG_W     = 3 * COORD_W;
	localparam int CFG_IDX_W = 3;
	localparam int AXES      = 3;

	localparam logic [COORD_W-1:0] SCALE_RESET = COORD_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_POINT   = 3'd0,
		REG_END_POINT     = 3'd1,
		REG_START_TANGENT = 3'd2,
		REG_END_TANGENT   = 3'd3,
		REG_TANGENT_SCALE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0]          start_point;
		logic [CFG_W-1:0]          end_point;
		logic [CFG_W-1:0]          start_tangent;
		logic [CFG_W-1:0]          end_tangent;
		logic signed [COORD_W-1:0] scale;
	} cfg_t;

	typedef struct packed {
		logic signed [H_W-1:0] h00;
		logic signed [H_W-1:0] h01;
		logic signed [H_W-1:0] h10;
		logic signed [H_W-1:0] h11;
	} basis_t;

endpackage

`default_nettype wire

// ----- hdl/chp3d_if.sv -----
// -----------------------------------------------------------------------------
// chp3d_param_if / chp3d_point_if
// Valid/ready channels for curve parameter requests and curve point results.
// -----------------------------------------------------------------------------
`default_nettype none

interface chp3d_param_if
	import chp3d_pkg::*;
;
	logic           valid;
	logic           ready;
	logic [T_W-1:0] curve_param;

	modport source (output valid, output curve_param, input ready);
	modport sink   (input valid, input curve_param, output ready);
endinterface

interface chp3d_point_if
	import chp3d_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;

	modport source (output valid, output out_x, output out_y, output out_z, input ready);
	modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

`default_nettype wire

// ----- hdl/chp3d_cfg.sv -----
// -----------------------------------------------------------------------------
// chp3d_cfg
// Configuration register file: curve points, tangents and tangent scale.
// -----------------------------------------------------------------------------
`default_nettype none

module chp3d_cfg
	import chp3d_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_point   <= '0;
			cfg_q.end_point     <= '0;
			cfg_q.start_tangent <= '0;
			cfg_q.end_tangent   <= '0;
			cfg_q.scale         <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_POINT:   cfg_q.start_point   <= cfg_wdata;
				REG_END_POINT:     cfg_q.end_point     <= cfg_wdata;
				REG_START_TANGENT: cfg_q.start_tangent <= cfg_wdata;
				REG_END_TANGENT:   cfg_q.end_tangent   <= cfg_wdata;
				REG_TANGENT_SCALE: cfg_q.scale         <= cfg_wdata[COORD_W-1:0];
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/chp3d_basis.sv -----
// -----------------------------------------------------------------------------
// chp3d_basis
// Stages 1 to 3: clamp t, form t^2 and t^3, then the four Hermite basis values.
// -----------------------------------------------------------------------------
`default_nettype none

module chp3d_basis
	import chp3d_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_vld,
	input  wire logic [T_W-1:0] curve_param,
	output logic                vld_s3,
	output basis_t              basis_s3
);

	logic           vld_s1, vld_s2;
	logic [T_W-1:0] t_s1, t2_s1;
	logic [T_W-1:0] t_s2, t2_s2, t3_s2;

	logic [T_W-1:0]  t_clamp;
	logic [SQ_W-1:0] sq;
	logic [SQ_W-1:0] cube;
	logic [H_W-1:0]  t_h, t2_h, t3_h, t2x3, t3x2;

	// Stage 1: clamp and square
	always_comb begin
		t_clamp = (curve_param > T_ONE) ? T_ONE : curve_param;
		sq      = SQ_W'(t_clamp) * SQ_W'(t_clamp) + SQ_W'(T_HALF);
	end

	// Stage 2: cube
	assign cube = SQ_W'(t2_s1) * SQ_W'(t_s1) + SQ_W'(T_HALF);

	// Stage 3: basis
	always_comb begin
		t_h  = H_W'(t_s2);
		t2_h = H_W'(t2_s2);
		t3_h = H_W'(t3_s2);
		t2x3 = t2_h + (t2_h << 1);
		t3x2 = t3_h << 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1         <= t_clamp;
			t2_s1        <= sq[FRAC_W +: T_W];
			t_s2         <= t_s1;
			t2_s2        <= t2_s1;
			t3_s2        <= cube[FRAC_W +: T_W];
			basis_s3.h00 <= t3x2 - t2x3 + H_W'(T_ONE);
			basis_s3.h01 <= t2x3 - t3x2;
			basis_s3.h10 <= t3_h - (t2_h << 1) + t_h;
			basis_s3.h11 <= t3_h - t2_h;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/chp3d_axis.sv -----
// -----------------------------------------------------------------------------
// chp3d_axis
// Stages 4 to 7 for one axis: basis products, rounding, tangent scaling and
// the saturated result.
// -----------------------------------------------------------------------------
`default_nettype none

module chp3d_axis
	import chp3d_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire basis_t                    basis,
	input  wire logic signed [COORD_W-1:0] p0,
	input  wire logic signed [COORD_W-1:0] p1,
	input  wire logic signed [COORD_W-1:0] tg0,
	input  wire logic signed [COORD_W-1:0] tg1,
	input  wire logic signed [COORD_W-1:0] scale,
	output logic signed [COORD_W-1:0]      result_s7
);

	logic signed [PROD_W-1:0]  m00_s4, m01_s4, m10_s4, m11_s4;
	logic signed [RND_W-1:0]   a_s5, s_s5;
	logic signed [RND_W-1:0]   a_s6;
	logic signed [SPROD_W-1:0] prod_s6;

	logic signed [PT_W-1:0]  a_sum, s_sum;
	logic signed [SUM_W-1:0] total;
	logic        [R_W-1:0]   r;
	logic                    fits;
	logic [COORD_W-1:0]      sat;

	// Stage 5: add product pairs and round to 16 fraction bits
	always_comb begin
		a_sum = PT_W'(m00_s4) + PT_W'(m01_s4) + PT_W'(PT_HALF);
		s_sum = PT_W'(m10_s4) + PT_W'(m11_s4) + PT_W'(PT_HALF);
	end

	// Stage 7: combine, round to Q8.8 and saturate
	always_comb begin
		total = (SUM_W'(a_s6) <<< 8) + SUM_W'(prod_s6) + SUM_W'(OUT_HALF);
		r     = total[SUM_W-1:OUT_SH];
		fits  = (r[R_W-1:COORD_W-1] == '0) || (r[R_W-1:COORD_W-1] == '1);
		if (fits) begin
			sat = r[COORD_W-1:0];
		end else if (r[R_W-1]) begin
			sat = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m00_s4    <= $signed(basis.h00) * p0;
			m01_s4    <= $signed(basis.h01) * p1;
			m10_s4    <= $signed(basis.h10) * tg0;
			m11_s4    <= $signed(basis.h11) * tg1;
			a_s5      <= a_sum[PT_W-1:RND_SH];
			s_s5      <= s_sum[PT_W-1:RND_SH];
			a_s6      <= a_s5;
			prod_s6   <= s_s5 * scale;
			result_s7 <= sat;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/cubic_hermite_point_3d.sv -----
// -----------------------------------------------------------------------------
// cubic_hermite_point_3d
// Evaluates a 3D cubic Hermite curve at a stream of parameter values.
// -----------------------------------------------------------------------------
// Usage:
//   sample : one request per curve parameter t, unsigned Q1.16 (65536 = 1.0);
//            values above 1.0 are clamped to 1.0.
//   point  : one result per request, in request order: x, y, z in signed Q8.8,
//            each saturated to 16 bits.
//   cfg_*  : write port for start point, end point, the two tangents and the
//            tangent scale. Write only while no request is in flight.
// Throughput is one request per cycle unless the output stalls: seven pipeline
// stages, each holding at most one multiplier or one wide add, with the product
// of the rounded tangent sum and the scale set in a stage of its own.
// The whole pipeline advances together; when the receiver holds ready low with
// a result waiting, every stage holds and sample.ready drops, so nothing is
// lost or repeated. Bubbles flow through while the output register is free.
// Reset clears all valid bits and loads the registers with zero points and
// tangents and a tangent scale of 1.0.
// -----------------------------------------------------------------------------
`default_nettype none

module cubic_hermite_point_3d
	import chp3d_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	chp3d_param_if.sink               sample,
	chp3d_point_if.source             point
);

	cfg_t   cfg;
	basis_t basis_s3;
	logic   vld_s3;
	logic   vld_s4, vld_s5, vld_s6, vld_s7;
	logic   en;

	logic signed [COORD_W-1:0] res [AXES];

	// Advance when the output register is empty or its result is being taken
	assign en           = !vld_s7 || point.ready;
	assign sample.ready = en;

	chp3d_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Stages 1 to 3: t^2, t^3 and the basis values, shared by all axes
	chp3d_basis u_basis (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (sample.valid),
		.curve_param (sample.curve_param),
		.vld_s3      (vld_s3),
		.basis_s3    (basis_s3)
	);

	// Stages 4 to 7: one datapath per axis, x in the low bits of each register
	for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
		chp3d_axis u_axis (
			.clk       (clk),
			.en        (en),
			.basis     (basis_s3),
			.p0        (cfg.start_point[ax*COORD_W +: COORD_W]),
			.p1        (cfg.end_point[ax*COORD_W +: COORD_W]),
			.tg0       (cfg.start_tangent[ax*COORD_W +: COORD_W]),
			.tg1       (cfg.end_tangent[ax*COORD_W +: COORD_W]),
			.scale     (cfg.scale),
			.result_s7 (res[ax])
		);
	end

	// Valid bits for the axis stages; stage 7 is the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign point.valid = vld_s7;
	assign point.out_x = res[0];
	assign point.out_y = res[1];
	assign point.out_z = res[2];

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cubic Hermite curve point block: a table of
// directed requests, some with hand-worked points, then random configurations
// and parameter streams checked against a bit-exact fixed-point predictor.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_top
	import chp3d_pkg::*;
;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	// Kinds of directed row: a register write, a request checked by the
	// predictor, or a request whose point is written into the table by hand
	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_POINT,
		ROW_KNOWN
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_W-1:0]       wdata;
		logic [T_W-1:0]         t;
		point_t                 want;
	} dir_row_t;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam longint SAT_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint SAT_LO = -(longint'(1) <<< (COORD_W - 1));
	localparam point_t ORIGIN = '0;

	// Highest register index; everything above the tangent scale is unused
	localparam logic [CFG_IDX_W-1:0] REG_NONE = {CFG_IDX_W{1'b1}};

	localparam int N_PHASES        = 10;
	localparam int ITEMS_PER_PHASE = 143;
	localparam int PAUSE_PHASE     = 4;
	localparam int HOLD_AFTER      = 300;   // results seen before the long hold
	localparam int HOLD_CYCLES     = 400;   // well beyond the pipeline depth
	localparam int DRAIN_CYCLES    = 32;    // well beyond the pipeline depth
	localparam int CYCLE_LIMIT     = 1000000;

	localparam int DIR_ROWS = 34;

	// Directed table. Hand-worked points: with zero registers every point is
	// the origin; t = 0 gives the start point and t = 1.0 (or anything above,
	// which clamps) the end point, whatever the tangents; with both points at
	// the top of the range and tangents pulling apart, the scale drives the
	// sum past either end so the result saturates; with a zero scale the
	// tangents drop out. A write to an unused index must leave everything as
	// it was.
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{ROW_KNOWN, '0, '0, 17'h00000, ORIGIN},
		'{ROW_KNOWN, '0, '0, 17'h10000, ORIGIN},
		'{ROW_KNOWN, '0, '0, 17'h1FFFF, ORIGIN},
		'{ROW_WRITE, REG_START_POINT,   48'h0300_FE00_0100, '0, ORIGIN},
		'{ROW_WRITE, REG_END_POINT,     48'h0050_8000_7FFF, '0, ORIGIN},
		'{ROW_WRITE, REG_START_TANGENT, 48'h1234_8000_7FFF, '0, ORIGIN},
		'{ROW_WRITE, REG_END_TANGENT,   48'hFF00_7FFF_8000, '0, ORIGIN},
		'{ROW_KNOWN, '0, '0, 17'h00000, '{16'h0100, 16'hFE00, 16'h0300}},
		'{ROW_KNOWN, '0, '0, 17'h10000, '{COORD_MAX, COORD_MIN, 16'h0050}},
		'{ROW_KNOWN, '0, '0, 17'h10001, '{COORD_MAX, COORD_MIN, 16'h0050}},
		'{ROW_KNOWN, '0, '0, 17'h1FFFF, '{COORD_MAX, COORD_MIN, 16'h0050}},
		'{ROW_POINT, '0, '0, 17'h00001, ORIGIN},
		'{ROW_POINT, '0, '0, 17'h08000, ORIGIN},
		'{ROW_POINT, '0, '0, 17'h0FFFF, ORIGIN},
		'{ROW_POINT, '0, '0, 17'h05555, ORIGIN},
		// bits above the scale width must be ignored
		'{ROW_WRITE, REG_TANGENT_SCALE, 48'hFFFF_FFFF_7FFF, '0, ORIGIN},
		'{ROW_POINT, '0, '0, 17'h04000, ORIGIN},
		'{ROW_POINT, '0, '0, 17'h0C000, ORIGIN},
		'{ROW_WRITE, REG_TANGENT_SCALE, 48'h0000_0000_8000, '0, ORIGIN},
		'{ROW_POINT, '0, '0, 17'h04000, ORIGIN},
		'{ROW_POINT, '0, '0, 17'h0C000, ORIGIN},
		'{ROW_WRITE, REG_START_POINT,   48'h7FFF_7FFF_7FFF, '0, ORIGIN},
		'{ROW_WRITE, REG_END_POINT,     48'h7FFF_7FFF_7FFF, '0, ORIGIN},
		'{ROW_WRITE, REG_START_TANGENT, 48'h7FFF_7FFF_7FFF, '0, ORIGIN},
		'{ROW_WRITE, REG_END_TANGENT,   48'h8000_8000_8000, '0, ORIGIN},
		'{ROW_KNOWN, '0, '0, 17'h08000, '{COORD_MIN, COORD_MIN, COORD_MIN}},
		'{ROW_WRITE, REG_TANGENT_SCALE, 48'h0000_0000_7FFF, '0, ORIGIN},
		'{ROW_KNOWN, '0, '0, 17'h08000, '{COORD_MAX, COORD_MAX, COORD_MAX}},
		'{ROW_WRITE, REG_TANGENT_SCALE, 48'h0000_0000_0000, '0, ORIGIN},
		'{ROW_KNOWN, '0, '0, 17'h08000, '{COORD_MAX, COORD_MAX, COORD_MAX}},
		'{ROW_WRITE, REG_NONE,          48'h0000_0000_0000, '0, ORIGIN},
		'{ROW_KNOWN, '0, '0, 17'h00000, '{COORD_MAX, COORD_MAX, COORD_MAX}},
		'{ROW_WRITE, REG_TANGENT_SCALE, 48'h0000_0000_0100, '0, ORIGIN},
		'{ROW_POINT, '0, '0, 17'h08000, ORIGIN}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	chp3d_param_if sample_if ();
	chp3d_point_if point_if ();

	// Local copy of the register file, updated as each write goes out
	logic [CFG_W-1:0]          start_pt;
	logic [CFG_W-1:0]          end_pt;
	logic [CFG_W-1:0]          start_tan;
	logic [CFG_W-1:0]          end_tan;
	logic signed [COORD_W-1:0] tan_scale;

	// Points still owed by the block, oldest first
	point_t pending_points [$];

	int n_errors = 0;
	int n_points = 0;
	int n_cycles = 0;

	cubic_hermite_point_3d DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_if),
		.point     (point_if)
	);

	// 4 ns period
	always #2 clk = ~clk;

	// Hard stop in case the handshake locks up
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Curve point at parameter t from the current register copy. Basis
	// polynomials come from rounded t^2 and t^3; point and tangent sums are
	// each rounded to 16 fraction bits, the tangent sum is scaled, and the
	// total is rounded half-up to Q8.8 and clamped to the coordinate range.
	function automatic point_t eval_curve_point(input logic [T_W-1:0] t_in);
		longint unsigned t, t2, t3;
		longint h00, h01, h10, h11;
		longint p0, p1, d0, d1, a, s, sum, r;
		logic signed [COORD_W-1:0] axis_val [AXES];
		point_t pt;
		t = (t_in > T_ONE) ? T_ONE : t_in;
		t2 = (t * t + T_HALF) >> FRAC_W;
		t3 = (t2 * t + T_HALF) >> FRAC_W;
		h00 = 2 * longint'(t3) - 3 * longint'(t2) + longint'(T_ONE);
		h01 = 3 * longint'(t2) - 2 * longint'(t3);
		h10 = longint'(t3) - 2 * longint'(t2) + longint'(t);
		h11 = longint'(t3) - longint'(t2);
		for (int ax = 0; ax < AXES; ax++) begin
			p0 = longint'($signed(start_pt[ax*COORD_W +: COORD_W]));
			p1 = longint'($signed(end_pt[ax*COORD_W +: COORD_W]));
			d0 = longint'($signed(start_tan[ax*COORD_W +: COORD_W]));
			d1 = longint'($signed(end_tan[ax*COORD_W +: COORD_W]));
			a = (h00 * p0 + h01 * p1 + PT_HALF) >>> RND_SH;
			s = (h10 * d0 + h11 * d1 + PT_HALF) >>> RND_SH;
			sum = (a <<< 8) + s * longint'(tan_scale);
			r = (sum + OUT_HALF) >>> OUT_SH;
			if (r > SAT_HI)
				r = SAT_HI;
			if (r < SAT_LO)
				r = SAT_LO;
			axis_val[ax] = r[COORD_W-1:0];
		end
		pt.x = axis_val[0];
		pt.y = axis_val[1];
		pt.z = axis_val[2];
		return pt;
	endfunction

	// Mostly small coordinates so that curves stay in range, with a share
	// of full-range values and range ends
	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3, 4: return COORD_W'($urandom());
			default: return COORD_W'(int'($urandom_range(0, 2047)) - 1024);
		endcase
	endfunction

	// Leave the write enable high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_START_POINT:   start_pt = data;
			REG_END_POINT:     end_pt = data;
			REG_START_TANGENT: start_tan = data;
			REG_END_TANGENT:   end_tan = data;
			REG_TANGENT_SCALE: tan_scale = data[COORD_W-1:0];
			default: ;
		endcase
	endtask

	// Drop valid and hold until every owed point has come back
	task automatic wait_drained();
		sample_if.valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	// Offer one request, log its point once accepted, then idle for a
	// random gap unless running flat out
	task automatic offer(input logic [T_W-1:0] t, input bit have_want, input point_t want,
			input bit busy);
		int roll;
		int gap;
		sample_if.valid <= 1'b1;
		sample_if.curve_param <= t;
		do
			@(posedge clk);
		while (sample_if.ready !== 1'b1);
		pending_points.push_back(have_want ? want : eval_curve_point(t));
		roll = $urandom_range(0, 99);
		if (busy || roll < 65)
			gap = 0;
		else if (roll < 95)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 50);
		if (gap > 0) begin
			// scribble on the payload while valid is low
			sample_if.valid <= 1'b0;
			sample_if.curve_param <= T_W'($urandom());
			repeat (gap)
				@(posedge clk);
		end
	endtask

	task automatic compare_axis(input string axis, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, axis, want, got);
			n_errors++;
		end
	endtask

	// Result side: check every accepted point against the oldest owed one
	// and throttle ready. Quiet stretches keep ready high; once, after a few
	// hundred results, hold ready low long enough to back the whole pipe up.
	initial begin : point_sink
		int     stall_left;
		bit     held;
		int     roll;
		point_t want;
		stall_left = 0;
		held = 1'b0;
		point_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (point_if.valid === 1'b1 && point_if.ready === 1'b1) begin
				n_points++;
				if (pending_points.size() == 0) begin
					$display("%0t: unexpected point, expected none, got x=%h y=%h z=%h",
						$time, point_if.out_x, point_if.out_y, point_if.out_z);
					n_errors++;
				end else begin
					want = pending_points.pop_front();
					compare_axis("out_x", want.x, point_if.out_x);
					compare_axis("out_y", want.y, point_if.out_y);
					compare_axis("out_z", want.z, point_if.out_z);
				end
			end
			if (stall_left == 0 && !held && n_points >= HOLD_AFTER) begin
				held = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && (n_points / 128) % 3 != 1) begin
				roll = $urandom_range(0, 99);
				if (roll < 20)
					stall_left = $urandom_range(1, 3);
				else if (roll < 23)
					stall_left = $urandom_range(10, 40);
			end
			if (stall_left > 0) begin
				point_if.ready <= 1'b0;
				stall_left--;
			end else begin
				point_if.ready <= 1'b1;
			end
		end
	end

	// Request side: reset, the directed table, then random phases
	initial begin : stimulus
		bit                 writing;
		int                 pick;
		logic [T_W-1:0]     t;
		logic [COORD_W-1:0] scale;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		sample_if.valid <= 1'b0;
		sample_if.curve_param <= '0;
		start_pt = '0;
		end_pt = '0;
		start_tan = '0;
		end_tan = '0;
		tan_scale = SCALE_RESET;
		writing = 1'b0;

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: drain before the first of a run of writes, drop
		// the write enable before the next request
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_WRITE) begin
				if (!writing) begin
					wait_drained();
					writing = 1'b1;
				end
				write_reg(dir_tab[i].idx, dir_tab[i].wdata);
			end else begin
				if (writing) begin
					cfg_we <= 1'b0;
					writing = 1'b0;
				end
				offer(dir_tab[i].t, dir_tab[i].kind == ROW_KNOWN, dir_tab[i].want, 1'b0);
			end
		end

		// Random phases: fresh registers each time, scale taken through
		// both ends early on, and stray writes to unused indexes
		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			for (int r = REG_START_POINT; r <= REG_END_TANGENT; r++)
				write_reg(r[CFG_IDX_W-1:0], {rand_coord(), rand_coord(), rand_coord()});
			case (ph)
				0: scale = SCALE_RESET;
				1: scale = COORD_MAX;
				2: scale = COORD_MIN;
				default: scale = rand_coord();
			endcase
			write_reg(REG_TANGENT_SCALE, {$urandom(), scale});
			if (ph % 2 == 1)
				write_reg(CFG_IDX_W'($urandom_range(REG_TANGENT_SCALE + 1, REG_NONE)),
					{$urandom(), 16'($urandom())});
			cfg_we <= 1'b0;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// halfway through one phase, stop and let the block empty
				if (ph == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
					wait_drained();
				pick = $urandom_range(0, 99);
				if (pick < 5)
					t = T_W'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
				else if (pick < 8)
					t = pick[0] ? T_ONE : '0;
				else
					t = T_W'($urandom_range(0, T_ONE));
				offer(t, 1'b0, ORIGIN, ph % 3 == 0);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/chp3d_pkg.sv
hdl/chp3d_if.sv
hdl/chp3d_cfg.sv
hdl/chp3d_basis.sv
hdl/chp3d_axis.sv
hdl/cubic_hermite_point_3d.sv
bench/tb_top.sv
